[rtl/core/pdss_pkg.sv]
// ============================================================================
// pdss_pkg
// Shared types and constants of the packed DNA seed scanner.
// ============================================================================
package pdss_pkg;

    // Overflow chain store and chain limits.
    localparam int OVERFLOW_DEPTH = 32768;
    localparam int OVF_AW         = $clog2(OVERFLOW_DEPTH);
    localparam int MAX_CHAIN      = 32;
    localparam int CNT_W          = $clog2(MAX_CHAIN + 1);
    // Chain pointers reach OVERFLOW_DEPTH plus a chain length, so one bit above 16.
    localparam int SRC_W          = 17;

    // Word and table geometry.
    localparam int WORD_BASES = 8;
    localparam int BB_AW      = 2 * WORD_BASES;
    localparam int ENTRY_W    = 16;

    // Field widths.
    localparam int OFF_W  = 31;
    localparam int QOFF_W = 15;
    localparam int LC_W   = 6;
    localparam int CNT32  = 32;
    // Word counter width below the point where the offset always passes scan_end.
    localparam int K_W    = 29;

    // Channel widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int CFG_AW    = 2;

    localparam logic [OFF_W-1:0] HIT_LIMIT_RESET = OFF_W'(1024);

    typedef enum logic [1:0] {
        CMD_LOAD_BB  = 2'd0,
        CMD_LOAD_OVF = 2'd1,
        CMD_START    = 2'd2,
        CMD_BYTE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_HIT  = 2'd0,
        KIND_STOP = 2'd1,
        KIND_CUT  = 2'd2
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SCAN_START   = 2'd0,
        CFG_SCAN_END     = 2'd1,
        CFG_HIT_LIMIT    = 2'd2,
        CFG_CHAIN_MARGIN = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QSEL_BB   = 2'd0,
        QSEL_PEND = 2'd1,
        QSEL_ZERO = 2'd2
    } qsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT_HIT,
        ST_EMIT_STOP,
        ST_CH_READ0,
        ST_CH_FIRST,
        ST_CH_READ,
        ST_CH_DATA,
        ST_CH_CUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  load_src;
        logic  rd_ovf;
        logic  cap_pend;
        logic  emit;
        kind_t emit_kind;
        qsel_t q_sel;
        logic  emit_last;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lookup_go;
        logic bb_miss;
        logic bb_neg;
        logic over_budget;
        logic v_neg;
        logic n_at_max;
        logic out_free;
    } status_t;

endpackage

[rtl/core/pdss_ctrl.sv]
// ============================================================================
// pdss_ctrl
// Sequencer for table lookups, chain walks and result emission.
// ============================================================================
module pdss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  pdss_pkg::status_t st,
    output pdss_pkg::ctrl_t   ctrl,
    output logic              s_tready
);
    import pdss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && st.lookup_go) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (st.bb_miss) begin
                    state_next = ST_IDLE;
                end else if (st.over_budget) begin
                    state_next = ST_EMIT_STOP;
                end else if (!st.bb_neg) begin
                    state_next = ST_EMIT_HIT;
                end else begin
                    state_next = ST_CH_READ0;
                end
            end
            ST_EMIT_HIT, ST_EMIT_STOP, ST_CH_CUT: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CH_READ0: state_next = ST_CH_FIRST;
            ST_CH_FIRST: state_next = ST_CH_READ;
            ST_CH_READ:  state_next = ST_CH_DATA;
            ST_CH_DATA: begin
                // The held entry goes out once the following entry tells whether it is last.
                if (st.out_free) begin
                    if (st.v_neg) begin
                        state_next = ST_IDLE;
                    end else if (st.n_at_max) begin
                        state_next = ST_CH_CUT;
                    end else begin
                        state_next = ST_CH_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl           = '0;
        ctrl.emit_kind = KIND_HIT;
        ctrl.q_sel     = QSEL_ZERO;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                ctrl.accept = s_tvalid;
            end
            ST_LOOKUP: begin
                ctrl.load_src = 1'b1;
            end
            ST_EMIT_HIT: begin
                ctrl.emit      = st.out_free;
                ctrl.emit_kind = KIND_HIT;
                ctrl.q_sel     = QSEL_BB;
                ctrl.emit_last = 1'b1;
            end
            ST_EMIT_STOP: begin
                ctrl.emit      = st.out_free;
                ctrl.emit_kind = KIND_STOP;
                ctrl.emit_last = 1'b1;
            end
            ST_CH_READ0, ST_CH_READ: begin
                ctrl.rd_ovf = 1'b1;
            end
            ST_CH_FIRST: begin
                ctrl.cap_pend = 1'b1;
            end
            ST_CH_DATA: begin
                ctrl.emit      = st.out_free;
                ctrl.cap_pend  = st.out_free;
                ctrl.emit_kind = KIND_HIT;
                ctrl.q_sel     = QSEL_PEND;
                ctrl.emit_last = st.v_neg;
            end
            ST_CH_CUT: begin
                ctrl.emit      = st.out_free;
                ctrl.emit_kind = KIND_CUT;
                ctrl.emit_last = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[rtl/core/pdss_dp.sv]
// ============================================================================
// pdss_dp
// Datapath: tables, scan counters, configuration and the result register.
// ============================================================================
module pdss_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pdss_pkg::ctrl_t                  ctrl,
    output pdss_pkg::status_t                st,
    input  logic [pdss_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [pdss_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             cfg_we,
    input  logic [pdss_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [pdss_pkg::OFF_W-1:0]       cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pdss_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [pdss_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);
    import pdss_pkg::*;

    logic [BB_AW-1:0]   in_addr;
    logic [ENTRY_W-1:0] in_value;
    logic [7:0]         in_byte;
    cmd_t               in_cmd;

    assign in_addr  = s_tdata[15:0];
    assign in_value = s_tdata[31:16];
    assign in_byte  = s_tdata[39:32];
    assign in_cmd   = cmd_t'(s_tuser);

    // Configuration.
    logic [OFF_W-1:0] scan_start_reg;
    logic [OFF_W-1:0] scan_end_reg;
    logic [OFF_W-1:0] hit_limit_reg;
    logic [LC_W-1:0]  chain_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_start_reg   <= '0;
            scan_end_reg     <= '0;
            hit_limit_reg    <= HIT_LIMIT_RESET;
            chain_margin_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SCAN_START:   scan_start_reg   <= cfg_wdata;
                CFG_SCAN_END:     scan_end_reg     <= cfg_wdata;
                CFG_HIT_LIMIT:    hit_limit_reg    <= cfg_wdata;
                CFG_CHAIN_MARGIN: chain_margin_reg <= cfg_wdata[LC_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan state.
    logic [7:0]       prev_reg;
    logic             seen_reg;
    logic [K_W-1:0]   k_reg;
    logic             k_big_reg;
    logic [CNT32-1:0] hit_count_reg;
    logic             stopped_reg;
    logic [OFF_W-1:0] off_reg;

    logic             is_byte;
    logic [OFF_W:0]   off_sum;
    logic             in_range;
    logic [K_W:0]     k_inc;

    assign is_byte  = ctrl.accept && (in_cmd == CMD_BYTE) && !stopped_reg;
    assign off_sum  = {1'b0, scan_start_reg[OFF_W-1:2], 2'b00} + {1'b0, k_reg, 2'b00};
    assign in_range = !k_big_reg && !off_sum[OFF_W] && (off_sum[OFF_W-1:0] <= scan_end_reg);
    assign k_inc    = {1'b0, k_reg} + (K_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            seen_reg    <= 1'b0;
            k_reg       <= '0;
            k_big_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end else if (ctrl.accept && (in_cmd == CMD_START)) begin
            prev_reg    <= '0;
            seen_reg    <= 1'b0;
            k_reg       <= '0;
            k_big_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            if (is_byte) begin
                prev_reg <= in_byte;
                seen_reg <= 1'b1;
                // Once the count passes the counter, every later offset is past scan_end.
                if (seen_reg && !k_big_reg) begin
                    k_reg     <= k_inc[K_W-1:0];
                    k_big_reg <= k_inc[K_W];
                end
            end
            if (ctrl.emit && (ctrl.emit_kind == KIND_STOP)) begin
                stopped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_count_reg <= '0;
        end else if (ctrl.accept && (in_cmd == CMD_START)) begin
            hit_count_reg <= '0;
        end else if (ctrl.emit && (ctrl.emit_kind == KIND_HIT) && !(&hit_count_reg)) begin
            hit_count_reg <= hit_count_reg + CNT32'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (is_byte && seen_reg) begin
            off_reg <= off_sum[OFF_W-1:0];
        end
    end

    // Backbone table.
    logic [ENTRY_W-1:0] bb_mem [2**BB_AW];
    logic [ENTRY_W-1:0] bb_rdata_reg;
    logic               bb_we;
    logic               bb_re;

    assign bb_we = ctrl.accept && (in_cmd == CMD_LOAD_BB);
    assign bb_re = is_byte && seen_reg && in_range;

    always_ff @(posedge aclk) begin
        if (bb_we) begin
            bb_mem[in_addr] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (bb_re) begin
            bb_rdata_reg <= bb_mem[{prev_reg, in_byte}];
        end
    end

    // Overflow chain store.
    logic [ENTRY_W-1:0] ovf_mem [OVERFLOW_DEPTH];
    logic [ENTRY_W-1:0] ovf_rdata_reg;
    logic               ovf_ok_reg;
    logic [SRC_W-1:0]   src_reg;
    logic               ovf_we;

    assign ovf_we = ctrl.accept && (in_cmd == CMD_LOAD_OVF)
                    && (SRC_W'(in_addr) < SRC_W'(OVERFLOW_DEPTH));

    always_ff @(posedge aclk) begin
        if (ovf_we) begin
            ovf_mem[in_addr[OVF_AW-1:0]] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_ovf) begin
            ovf_rdata_reg <= ovf_mem[src_reg[OVF_AW-1:0]];
            ovf_ok_reg    <= (src_reg < SRC_W'(OVERFLOW_DEPTH));
        end
    end

    // The chain starts at the negated backbone entry.
    always_ff @(posedge aclk) begin
        if (ctrl.load_src) begin
            src_reg <= SRC_W'(0) - {{(SRC_W-ENTRY_W){bb_rdata_reg[ENTRY_W-1]}}, bb_rdata_reg};
        end else if (ctrl.rd_ovf) begin
            src_reg <= src_reg + SRC_W'(1);
        end
    end

    logic [QOFF_W-1:0] pend_q_reg;
    logic [CNT_W-1:0]  n_reg;

    // An address past the store reads as an all-ones chain end.
    always_ff @(posedge aclk) begin
        if (ctrl.cap_pend) begin
            pend_q_reg <= ovf_ok_reg ? ovf_rdata_reg[QOFF_W-1:0] : {QOFF_W{1'b1}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else if (ctrl.load_src) begin
            n_reg <= '0;
        end else if (ctrl.emit && (ctrl.q_sel == QSEL_PEND)) begin
            n_reg <= n_reg + CNT_W'(1);
        end
    end

    // Result register.
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [QOFF_W-1:0] out_q_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic              out_last_reg;
    logic [QOFF_W-1:0] q_mux;

    always_comb begin
        case (ctrl.q_sel)
            QSEL_BB:   q_mux = bb_rdata_reg[QOFF_W-1:0];
            QSEL_PEND: q_mux = pend_q_reg;
            default:   q_mux = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_kind_reg <= ctrl.emit_kind;
            out_q_reg    <= q_mux;
            out_off_reg  <= off_reg;
            out_last_reg <= ctrl.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-QOFF_W-OFF_W){1'b0}}, out_off_reg, out_q_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Status.
    assign st.lookup_go   = (in_cmd == CMD_BYTE) && !stopped_reg && seen_reg && in_range;
    assign st.bb_miss     = (bb_rdata_reg == {ENTRY_W{1'b1}});
    assign st.bb_neg      = bb_rdata_reg[ENTRY_W-1];
    // hit_count > hit_limit - chain margin, rearranged to stay unsigned.
    assign st.over_budget = ({1'b0, hit_count_reg} + (CNT32+1)'(chain_margin_reg))
                            > (CNT32+1)'(hit_limit_reg);
    assign st.v_neg       = !ovf_ok_reg || ovf_rdata_reg[ENTRY_W-1];
    assign st.n_at_max    = ((n_reg + CNT_W'(1)) == CNT_W'(MAX_CHAIN));
    assign st.out_free    = !out_valid_reg || m_tready;

endmodule

[rtl/core/packed_dna_seed_scanner.sv]
// ============================================================================
// packed_dna_seed_scanner
// Scans packed subject bytes for 8-base words in a backbone table and walks
// overflow chains, emitting the query offset of each hit, up to the chain and hit limits, with its subject offset.
// ============================================================================
// Load, start and non-lookup bytes are taken in the idle state; a byte whose word misses
// also passes the lookup state. A single hit or a stop passes the lookup state and is
// written to the output register from an emit state once the output is free. A chain walk
// alternates registered overflow-store reads and emits, and stalls while the output is full.
// Reset (aresetn low, synchronous) clears the scan state, the output valid and the
// registers to their defaults; the tables are not cleared and are undefined until written.
module packed_dna_seed_scanner (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // table_address [15:0], table_value [31:16], subject_byte [39:32]
    input  logic [pdss_pkg::S_TDATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [pdss_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // query offset [14:0], subject offset [45:15], zero [47:46]
    output logic [pdss_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind [1:0]
    output logic [pdss_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [pdss_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [pdss_pkg::OFF_W-1:0]      cfg_wdata
);
    import pdss_pkg::*;

    ctrl_t   ctrl;
    status_t st;

    pdss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .ctrl     (ctrl),
        .s_tready (s_tready)
    );

    pdss_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
